FILE: hw/rtl/fmcrl_pkg.sv
// ----------------------------------------------------------------------------
// fmcrl_pkg
// Shared constants and types for the first-match connection rule lookup.
// ----------------------------------------------------------------------------
package fmcrl_pkg;

   localparam int MAX_RULES  = 64;
   localparam int RULE_AW    = $clog2(MAX_RULES);
   localparam int CNT_W      = RULE_AW + 1;

   localparam int IP_W       = 32;
   localparam int PORT_W     = 16;
   localparam int PLEN_W     = 6;
   localparam int PROTO_W    = 3;
   localparam int PROF_W     = 16;
   localparam int SLOT_W     = 6;
   localparam int CNT_REG_W  = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENTRY_COUNT     = 2'd0,
      REG_DEFAULT_PROFILE = 2'd1
   } csr_reg_type;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic              any;
      logic [PLEN_W-1:0] plen;
      logic [IP_W-1:0]   ip;
   } side_type;

   typedef struct packed {
      logic [PROF_W-1:0]  profile;
      logic [PROTO_W-1:0] proto;
      side_type           loc_side;
      side_type           rmt_side;
   } rule_type;

   typedef struct packed {
      logic [PROTO_W-1:0] proto;
      logic [IP_W-1:0]    rmt_ip;
      logic [PORT_W-1:0]  rmt_port;
      logic [IP_W-1:0]    loc_ip;
      logic [PORT_W-1:0]  loc_port;
   } key_type;

endpackage

FILE: hw/rtl/first_match_connection_rule_lookup_top.sv
// ----------------------------------------------------------------------------
// first_match_connection_rule_lookup_top
// A lookup walks the rules in slot order and stops at the first hit; a miss
//   walks n rules (n = entry_count, capped at the table depth).
// Throughput: one lookup at a time; busy stays high until the result strobes,
//   the walk reads one rule per cycle from the single table read port.
// Reset: synchronous, clears control and both registers; table undefined.
// ----------------------------------------------------------------------------
module first_match_connection_rule_lookup_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_mode,
   input  logic [fmcrl_pkg::SLOT_W-1:0]      req_entry_index,
   input  logic [fmcrl_pkg::PROTO_W-1:0]     req_proto,
   input  logic [fmcrl_pkg::IP_W-1:0]        req_rmt_ip,
   input  logic [fmcrl_pkg::PLEN_W-1:0]      req_rmt_prefix_len,
   input  logic                              req_rmt_wild,
   input  logic [fmcrl_pkg::PORT_W-1:0]      req_rmt_port,
   input  logic [fmcrl_pkg::IP_W-1:0]        req_loc_ip,
   input  logic [fmcrl_pkg::PLEN_W-1:0]      req_loc_prefix_len,
   input  logic                              req_loc_wild,
   input  logic [fmcrl_pkg::PORT_W-1:0]      req_loc_port,
   input  logic [fmcrl_pkg::PROF_W-1:0]      req_profile_id,
   output logic                              rsp_valid,
   output logic                              rsp_matched,
   output logic [fmcrl_pkg::SLOT_W-1:0]      rsp_match_index,
   output logic [fmcrl_pkg::PROF_W-1:0]      rsp_result_profile,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fmcrl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fmcrl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fmcrl_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type             state_ff, state_in;
   key_type               key_ff, key_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [RULE_AW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_matched_ff, rsp_matched_in;
   logic [SLOT_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [PROF_W-1:0]     rsp_profile_ff, rsp_profile_in;
   logic [CNT_REG_W-1:0]  entry_count_ff;
   logic [PROF_W-1:0]     default_profile_ff;

   logic                  accept;
   logic                  wr_en;
   rule_type              wr_rule;
   logic                  rd_en;
   rule_type              rd_rule;
   logic                  hit;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign wr_en = accept && req_mode && (32'(req_entry_index) < 32'(MAX_RULES));

   assign wr_rule.profile           = req_profile_id;
   assign wr_rule.proto             = req_proto;
   assign wr_rule.rmt_side.port     = req_rmt_port;
   assign wr_rule.rmt_side.any      = req_rmt_wild;
   assign wr_rule.rmt_side.plen     = req_rmt_prefix_len;
   assign wr_rule.rmt_side.ip       = req_rmt_ip;
   assign wr_rule.loc_side.port     = req_loc_port;
   assign wr_rule.loc_side.any      = req_loc_wild;
   assign wr_rule.loc_side.plen     = req_loc_prefix_len;
   assign wr_rule.loc_side.ip       = req_loc_ip;

   fmcrl_rule_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (RULE_AW'(req_entry_index)),
      .wr_data (wr_rule),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[RULE_AW-1:0]),
      .rd_data (rd_rule)
   );

   fmcrl_match u_match (
      .key  (key_ff),
      .rule (rd_rule),
      .hit  (hit)
   );

   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      n_in           = n_ff;
      idx_in         = idx_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_matched_in = rsp_matched_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_profile_in = rsp_profile_ff;
      rd_en          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in.proto    = req_proto;
               key_in.rmt_ip   = req_rmt_ip;
               key_in.rmt_port = req_rmt_port;
               key_in.loc_ip   = req_loc_ip;
               key_in.loc_port = req_loc_port;
               if (32'(entry_count_ff) > 32'(MAX_RULES)) begin
                  n_in = CNT_W'(MAX_RULES);
               end else begin
                  n_in = CNT_W'(entry_count_ff);
               end
               idx_in = '0;
               if (req_mode) begin
                  rsp_valid_in   = 1'b1;
                  rsp_matched_in = 1'b0;
                  rsp_index_in   = '0;
                  rsp_profile_in = '0;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (cmp_vld_ff && hit) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = 1'b1;
               rsp_index_in   = SLOT_W'(cmp_idx_ff);
               rsp_profile_in = rd_rule.profile;
               state_in       = ST_IDLE;
            end else if (idx_ff == n_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = 1'b0;
               rsp_index_in   = '0;
               rsp_profile_in = default_profile_ff;
               state_in       = ST_IDLE;
            end else begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff[RULE_AW-1:0];
               idx_in     = idx_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff         <= key_in;
      n_ff           <= n_in;
      idx_ff         <= idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_profile_ff <= rsp_profile_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff     <= '0;
         default_profile_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_ENTRY_COUNT:     entry_count_ff     <= csr_wdata[CNT_REG_W-1:0];
            REG_DEFAULT_PROFILE: default_profile_ff <= csr_wdata[PROF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_matched        = rsp_matched_ff;
   assign rsp_match_index    = rsp_index_ff;
   assign rsp_result_profile = rsp_profile_ff;

endmodule

FILE: hw/rtl/fmcrl_rule_mem.sv
// ----------------------------------------------------------------------------
// fmcrl_rule_mem
// Rule table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fmcrl_rule_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [fmcrl_pkg::RULE_AW-1:0] wr_addr,
   input  fmcrl_pkg::rule_type        wr_data,
   input  logic                       rd_en,
   input  logic [fmcrl_pkg::RULE_AW-1:0] rd_addr,
   output fmcrl_pkg::rule_type        rd_data
);
   import fmcrl_pkg::*;

   rule_type mem [MAX_RULES];
   rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/fmcrl_match.sv
// ----------------------------------------------------------------------------
// fmcrl_match
// Compare unit: checks one rule against the lookup key.
// ----------------------------------------------------------------------------
module fmcrl_match (
   input  fmcrl_pkg::key_type  key,
   input  fmcrl_pkg::rule_type rule,
   output logic                hit
);
   import fmcrl_pkg::*;

   function automatic logic side_hit(side_type r, logic [IP_W-1:0] ip,
                                     logic [PORT_W-1:0] port);
      logic [IP_W-1:0] mask;
      logic            port_ok;
      for (int k = 0; k < IP_W; k++) begin
         mask[IP_W-1-k] = (PLEN_W'(k) < r.plen);
      end
      port_ok = (r.port == '0) || (r.port == port);
      return port_ok && (r.any || (((ip ^ r.ip) & mask) == '0));
   endfunction

   logic proto_ok;

   assign proto_ok = (rule.proto == '0) || (key.proto == '0) || (rule.proto == key.proto);
   assign hit = proto_ok
              && side_hit(rule.rmt_side, key.rmt_ip, key.rmt_port)
              && side_hit(rule.loc_side, key.loc_ip, key.loc_port);

endmodule
